/* src/rrmm_pkg.sv */
// shared types and constants for the row range matrix multiply core
`default_nettype none

package rrmm_pkg;

    localparam int DEF_MAX_INNER  = 1024;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_DATA_WIDTH = 16;

    localparam int STORE_AW    = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    localparam int ROW_W       = 16;
    localparam int COL_W       = 6;
    localparam int SUM_W       = 42;
    localparam int OUT_TDATA_W = ROW_W + COL_W + SUM_W;

    localparam int INNER_REG_W = 11;
    localparam int COLS_REG_W  = 7;
    localparam int FIRST_REG_W = 16;
    localparam int STOP_REG_W  = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_CMP_W   = 13;

    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = 2;

    localparam logic MODE_B_LOAD = 1'b0;
    localparam logic MODE_A_ELEM = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_SIZE = 2'd0,
        CFG_OUT_COLS   = 2'd1,
        CFG_FIRST_ROW  = 2'd2,
        CFG_STOP_ROW   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_ctrl_state;

    typedef struct packed {
        logic                b_wr;
        logic                wp_clr;
        logic                a_load;
        logic                issue;
        logic [STORE_AW-1:0] rd_addr;
        logic [COL_W-1:0]    col;
        logic                first;
        logic                emit;
        logic                last_col;
        logic [ROW_W-1:0]    row;
        logic                done;
    } t_dp_cmd;

    typedef struct packed {
        logic space_ok;
        logic busy;
    } t_dp_sts;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             done;
    } t_out_item;

endpackage

`default_nettype wire

/* src/row_range_matrix_multiply_core.sv */
// top level of the row range matrix multiply core
// Usage: configure inner_size, out_cols, first_row and stop_row on the cfg
// channel (index 0..3) while the core is idle. Stream the b matrix row-major
// on the slave channel with tuser = 0, then a elements row-major with
// tuser = 1. Each a element multiplies one b row into the row of column
// accumulators; the last element of an a row sends out_cols results on the
// master channel, one per column, tlast on the last column and tuser set on
// every result of the final row before stop_row.
// Flow: b elements are taken back to back while the core is idle. For an a
// element the sequencer issues one column per cycle, pausing on a row's last
// element while the result queue has no room, into a read, multiply, accumulate
// pipeline sharing one multiplier and one accumulator memory.
// Reset clears the counters, the b write pointer and the accumulator valid
// bits at once; there is no clearing pass. When the receiver stalls, a four
// deep result queue fills and column issue pauses until space returns; the
// slave side stays closed until the element in flight has been issued and drained.
`default_nettype none

module row_range_matrix_multiply_core #(
    parameter int MAX_INNER  = rrmm_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS   = rrmm_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = rrmm_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,  // value
    input  wire logic                                  i_s_axis_tuser,  // mode
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    output logic [rrmm_pkg::OUT_TDATA_W-1:0]           o_m_axis_tdata,  // row, col, product_sum
    output logic                                       o_m_axis_tlast,
    output logic                                       o_m_axis_tuser,  // done_res
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [rrmm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [rrmm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    rrmm_pkg::t_dp_cmd   cmd;
    rrmm_pkg::t_dp_sts   sts;
    rrmm_pkg::t_out_item out_item;

    rrmm_ctrl #(
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_mode      (i_s_axis_tuser),
        .o_ready     (o_s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rrmm_datapath #(
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (i_s_axis_tdata[DATA_WIDTH-1:0]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_item  (out_item)
    );

    assign o_m_axis_tdata = {out_item.sum, out_item.col, out_item.row};
    assign o_m_axis_tlast = out_item.last;
    assign o_m_axis_tuser = out_item.done;

endmodule

`default_nettype wire

/* src/rrmm_out_buf.sv */
// small result queue in front of the output channel
`default_nettype none

module rrmm_out_buf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire rrmm_pkg::t_out_item i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output rrmm_pkg::t_out_item      o_item,
    output logic [rrmm_pkg::OBUF_AW:0] o_occ,
    output logic                     o_pop
);

    rrmm_pkg::t_out_item r_mem [rrmm_pkg::OBUF_DEPTH];
    logic [rrmm_pkg::OBUF_AW-1:0] r_wr_ptr;
    logic [rrmm_pkg::OBUF_AW-1:0] r_rd_ptr;
    logic [rrmm_pkg::OBUF_AW:0]   r_occ;

    assign o_valid = (r_occ != '0);
    assign o_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_occ   = r_occ;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (o_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, o_pop})
                2'b10:   r_occ <= r_occ + 1'b1;
                2'b01:   r_occ <= r_occ - 1'b1;
                default: r_occ <= r_occ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/rrmm_datapath.sv */
// b store, accumulator memory and multiply-accumulate pipeline
`default_nettype none

module rrmm_datapath #(
    parameter int MAX_COLS   = rrmm_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = rrmm_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rrmm_pkg::t_dp_cmd     i_cmd,
    output rrmm_pkg::t_dp_sts          o_sts,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output rrmm_pkg::t_out_item        o_out_item
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [DATA_WIDTH-1:0] r_b_mem [rrmm_pkg::STORE_DEPTH];
    logic [rrmm_pkg::SUM_W-1:0] r_acc_mem [MAX_COLS];
    logic [MAX_COLS-1:0] r_acc_vld;
    logic [rrmm_pkg::STORE_AW-1:0] r_wp;

    logic signed [DATA_WIDTH-1:0] r_a;

    // stage 1: memory read data
    logic                          r_s1_v;
    logic [rrmm_pkg::COL_W-1:0]    r_s1_col;
    logic                          r_s1_first;
    logic                          r_s1_emit;
    logic                          r_s1_last;
    logic [rrmm_pkg::ROW_W-1:0]    r_s1_row;
    logic                          r_s1_done;
    logic                          r_s1_ent_vld;
    logic signed [DATA_WIDTH-1:0]  r_b_rd;
    logic signed [rrmm_pkg::SUM_W-1:0] r_acc_rd;

    // stage 2: product and accumulator base
    logic                          r_s2_v;
    logic [rrmm_pkg::COL_W-1:0]    r_s2_col;
    logic                          r_s2_emit;
    logic                          r_s2_last;
    logic [rrmm_pkg::ROW_W-1:0]    r_s2_row;
    logic                          r_s2_done;
    logic signed [2*DATA_WIDTH-1:0]    r_s2_prod;
    logic signed [rrmm_pkg::SUM_W-1:0] r_s2_base;

    logic signed [rrmm_pkg::SUM_W-1:0] n_sum;
    logic [1:0]                    inflight;
    logic [rrmm_pkg::OBUF_AW:0]    occ;
    logic                          pop;
    logic                          push;
    rrmm_pkg::t_out_item           push_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.b_wr) begin
            r_b_mem[r_wp] <= i_value;
        end
        if (i_cmd.issue) begin
            r_b_rd <= r_b_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_acc_mem[r_s2_col[CW-1:0]] <= n_sum;
        end
        if (i_cmd.issue) begin
            r_acc_rd <= r_acc_mem[i_cmd.col[CW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_acc_vld <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
        end else begin
            if (i_cmd.wp_clr) begin
                r_wp <= '0;
            end else if (i_cmd.b_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (r_s2_v) begin
                r_acc_vld[r_s2_col[CW-1:0]] <= 1'b1;
            end
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.a_load) begin
            r_a <= i_value;
        end
        r_s1_col     <= i_cmd.col;
        r_s1_first   <= i_cmd.first;
        r_s1_emit    <= i_cmd.emit;
        r_s1_last    <= i_cmd.last_col;
        r_s1_row     <= i_cmd.row;
        r_s1_done    <= i_cmd.done;
        r_s1_ent_vld <= r_acc_vld[i_cmd.col[CW-1:0]];

        r_s2_col  <= r_s1_col;
        r_s2_emit <= r_s1_emit;
        r_s2_last <= r_s1_last;
        r_s2_row  <= r_s1_row;
        r_s2_done <= r_s1_done;
        r_s2_prod <= r_a * r_b_rd;
        r_s2_base <= (r_s1_first || !r_s1_ent_vld) ? '0 : r_acc_rd;
    end

    assign n_sum = r_s2_base + rrmm_pkg::SUM_W'(r_s2_prod);

    assign push = r_s2_v && r_s2_emit;
    always_comb begin
        push_item.sum  = n_sum;
        push_item.col  = r_s2_col;
        push_item.row  = r_s2_row;
        push_item.last = r_s2_last;
        push_item.done = r_s2_done;
    end

    rrmm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item),
        .o_occ   (occ),
        .o_pop   (pop)
    );

    // results already on their way into the queue
    assign inflight = {1'b0, r_s1_v && r_s1_emit} + {1'b0, r_s2_v && r_s2_emit};

    always_comb begin
        o_sts.busy     = r_s1_v || r_s2_v;
        o_sts.space_ok = ({1'b0, occ} + {2'b00, inflight})
                         < ((rrmm_pkg::OBUF_AW + 2)'(rrmm_pkg::OBUF_DEPTH) + {3'b000, pop});
    end

endmodule

`default_nettype wire

/* src/rrmm_ctrl.sv */
// controller: configuration registers, row and inner counters, column sequencer
`default_nettype none

module rrmm_ctrl #(
    parameter int MAX_INNER = rrmm_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS  = rrmm_pkg::DEF_MAX_COLS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic                            i_mode,
    output logic                                 o_ready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rrmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rrmm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rrmm_pkg::t_dp_cmd                    o_cmd,
    input  wire rrmm_pkg::t_dp_sts               i_sts
);

    localparam int ICW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    rrmm_pkg::t_ctrl_state r_state;
    rrmm_pkg::t_ctrl_state n_state;

    logic [rrmm_pkg::INNER_REG_W-1:0] r_inner_size;
    logic [rrmm_pkg::COLS_REG_W-1:0]  r_out_cols;
    logic [rrmm_pkg::FIRST_REG_W-1:0] r_first_row;
    logic [rrmm_pkg::STOP_REG_W-1:0]  r_stop_row;

    logic [ICW-1:0]                r_inner_cnt;
    logic [rrmm_pkg::ROW_W-1:0]    r_row_cnt;

    logic [rrmm_pkg::COL_W-1:0]      r_col;
    logic [rrmm_pkg::COLS_REG_W-1:0] r_cols;
    logic [rrmm_pkg::STORE_AW-1:0]   r_base;
    logic                            r_first;
    logic                            r_emit;
    logic [rrmm_pkg::ROW_W-1:0]      r_row;
    logic                            r_done;

    logic                            accept;
    logic                            a_take;
    logic [rrmm_pkg::CNT_CMP_W-1:0]  inner_eff;
    logic [rrmm_pkg::COLS_REG_W-1:0] cols_eff;
    logic [rrmm_pkg::STOP_REG_W-1:0] cur_row;
    logic                            in_range;
    logic                            last_elem;
    logic                            final_row;
    logic [31:0]                     base_full;
    logic                            last_col;

    always_comb begin
        if (r_inner_size == '0) begin
            inner_eff = rrmm_pkg::CNT_CMP_W'(1);
        end else if (rrmm_pkg::CNT_CMP_W'(r_inner_size) > rrmm_pkg::CNT_CMP_W'(MAX_INNER)) begin
            inner_eff = rrmm_pkg::CNT_CMP_W'(MAX_INNER);
        end else begin
            inner_eff = rrmm_pkg::CNT_CMP_W'(r_inner_size);
        end
        if (r_out_cols == '0) begin
            cols_eff = rrmm_pkg::COLS_REG_W'(1);
        end else if (r_out_cols > rrmm_pkg::COLS_REG_W'(MAX_COLS)) begin
            cols_eff = rrmm_pkg::COLS_REG_W'(MAX_COLS);
        end else begin
            cols_eff = r_out_cols;
        end
    end

    assign cur_row   = rrmm_pkg::STOP_REG_W'(r_first_row) + rrmm_pkg::STOP_REG_W'(r_row_cnt);
    assign in_range  = cur_row < r_stop_row;
    assign last_elem = (rrmm_pkg::CNT_CMP_W'(r_inner_cnt) + 1'b1) >= inner_eff;
    assign final_row = (cur_row + 1'b1) == r_stop_row;
    assign base_full = 32'(r_inner_cnt) * 32'(cols_eff);
    assign last_col  = ({1'b0, r_col} == (r_cols - 1'b1));

    assign accept = i_valid && o_ready;
    assign a_take = accept && (i_mode == rrmm_pkg::MODE_A_ELEM) && in_range;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrmm_pkg::ST_IDLE: begin
                if (a_take) begin
                    n_state = rrmm_pkg::ST_RUN;
                end
            end
            rrmm_pkg::ST_RUN: begin
                if (o_cmd.issue && last_col) begin
                    n_state = rrmm_pkg::ST_DRAIN;
                end
            end
            rrmm_pkg::ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = rrmm_pkg::ST_IDLE;
                end
            end
            default: n_state = rrmm_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = 1'b0;
        o_cfg_ready = 1'b1;
        o_cmd       = '0;
        case (r_state)
            rrmm_pkg::ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.b_wr   = i_valid && (i_mode == rrmm_pkg::MODE_B_LOAD);
                o_cmd.wp_clr = i_valid && (i_mode == rrmm_pkg::MODE_A_ELEM);
                o_cmd.a_load = i_valid && (i_mode == rrmm_pkg::MODE_A_ELEM) && in_range;
            end
            rrmm_pkg::ST_RUN: begin
                o_cmd.issue = !r_emit || i_sts.space_ok;
            end
            rrmm_pkg::ST_DRAIN: begin
                o_cmd.issue = 1'b0;
            end
            default: o_cmd = '0;
        endcase
        o_cmd.rd_addr  = r_base + rrmm_pkg::STORE_AW'(r_col);
        o_cmd.col      = r_col;
        o_cmd.first    = r_first;
        o_cmd.emit     = r_emit;
        o_cmd.last_col = last_col;
        o_cmd.row      = r_row;
        o_cmd.done     = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rrmm_pkg::ST_IDLE;
            r_inner_size <= rrmm_pkg::INNER_REG_W'(1);
            r_out_cols   <= rrmm_pkg::COLS_REG_W'(1);
            r_first_row  <= '0;
            r_stop_row   <= '0;
            r_inner_cnt  <= '0;
            r_row_cnt    <= '0;
            r_col        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (rrmm_pkg::t_cfg_idx'(i_cfg_index))
                    rrmm_pkg::CFG_INNER_SIZE:
                        r_inner_size <= i_cfg_data[rrmm_pkg::INNER_REG_W-1:0];
                    rrmm_pkg::CFG_OUT_COLS:
                        r_out_cols <= i_cfg_data[rrmm_pkg::COLS_REG_W-1:0];
                    rrmm_pkg::CFG_FIRST_ROW:
                        r_first_row <= i_cfg_data[rrmm_pkg::FIRST_REG_W-1:0];
                    rrmm_pkg::CFG_STOP_ROW:
                        r_stop_row <= i_cfg_data[rrmm_pkg::STOP_REG_W-1:0];
                    default: r_stop_row <= r_stop_row;
                endcase
            end
            if (a_take) begin
                r_col <= '0;
                if (last_elem) begin
                    r_inner_cnt <= '0;
                    r_row_cnt   <= final_row ? '0 : r_row_cnt + 1'b1;
                end else begin
                    r_inner_cnt <= r_inner_cnt + 1'b1;
                end
            end else if (o_cmd.issue) begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // per-item context, latched when an a element is taken
    always_ff @(posedge i_clk) begin
        if (a_take) begin
            r_cols  <= cols_eff;
            r_base  <= base_full[rrmm_pkg::STORE_AW-1:0];
            r_first <= (r_inner_cnt == '0);
            r_emit  <= last_elem;
            r_row   <= cur_row[rrmm_pkg::ROW_W-1:0];
            r_done  <= final_row;
        end
    end

endmodule

`default_nettype wire

/* src/rrmm_checker.sv */
// port-level checks for the row range matrix multiply core
`default_nettype none

module rrmm_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic                            i_s_axis_tuser,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [rrmm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                            o_m_axis_tlast,
    input wire logic                            o_m_axis_tuser
);

    // no result is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // a b load transfer leaves the input side open
    a_bload_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser |=> o_s_axis_tready)
        else $error("input closed after b load");

endmodule

bind row_range_matrix_multiply_core rrmm_checker u_rrmm_checker (.*);

`default_nettype wire

/* dv/row_range_matrix_multiply_core_tb.sv */
// self-checking testbench for the row range matrix multiply core
`timescale 1ns / 1ps

module row_range_matrix_multiply_core_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 400;
    localparam int CFG_QUIET    = 80;
    localparam int END_QUIET    = 100;
    localparam int N_STEPS      = 32;

    typedef enum {STEP_CFG, STEP_XFER} t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [1:0]  sel;
        logic [16:0] data;
        bit          typed;
        longint      sum;
    } t_step;

    typedef struct {
        logic [rrmm_pkg::ROW_W-1:0] row;
        logic [rrmm_pkg::COL_W-1:0] col;
        logic [rrmm_pkg::SUM_W-1:0] sum;
        logic                       last;
        logic                       done;
    } t_c_elem;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic [15:0]                      i_s_axis_tdata = '0;
    logic                             i_s_axis_tuser = 1'b0;
    logic                             i_m_axis_tready = 1'b1;
    logic                             i_cfg_valid = 1'b0;
    logic [rrmm_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [rrmm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    wire                              o_s_axis_tready;
    wire                              o_m_axis_tvalid;
    wire [rrmm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;
    wire                              o_m_axis_tlast;
    wire                              o_m_axis_tuser;
    wire                              o_cfg_ready;

    // shadow of the block state
    logic [10:0]       cfg_inner = 11'd1;
    logic [6:0]        cfg_cols  = 7'd1;
    logic [15:0]       cfg_first = '0;
    logic [16:0]       cfg_stop  = '0;
    logic [15:0]       b_mem [rrmm_pkg::STORE_DEPTH];
    bit                b_written [rrmm_pkg::STORE_DEPTH];
    logic [15:0]       b_wp = '0;
    longint            acc_row [rrmm_pkg::DEF_MAX_COLS];
    logic [9:0]        inner_cnt = '0;
    logic [15:0]       row_cnt = '0;

    t_c_elem           expected_c [$];
    int                last_pushed;

    int                b_loads, a_used, a_ignored, cfg_writes, phases;
    int                results_seen, rows_seen, errors;
    int unsigned       cycle_count;
    bit                quiet;
    int                gap_pct = 20;
    int                ready_pct = 20;
    int                stall_left;

    t_step dir_steps [N_STEPS] = '{
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h00100, 1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_STOP_ROW,   17'd2,     1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h07FFF, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h08000, 1'b1, -1073709056},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h07FFF, 1'b1, 1073676289},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h00100, 1'b1, 8388352},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h08000, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h08000, 1'b1, 1073741824},
        '{STEP_CFG,  rrmm_pkg::CFG_INNER_SIZE, 17'd0,     1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_OUT_COLS,   17'd0,     1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_FIRST_ROW,  17'd65535, 1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_STOP_ROW,   17'd65536, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h0FFFF, 1'b1, 32768},
        '{STEP_CFG,  rrmm_pkg::CFG_INNER_SIZE, 17'd3,     1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_OUT_COLS,   17'd2,     1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_FIRST_ROW,  17'd0,     1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_STOP_ROW,   17'd1,     1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h00001, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h0FFFF, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h00100, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h08000, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h07FFF, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_B_LOAD,    17'h01234, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h00200, 1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h0FF00, 1'b0, 0},
        // shrinking inner_size mid-row ends the row on the next a element
        '{STEP_CFG,  rrmm_pkg::CFG_INNER_SIZE, 17'd2,     1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h04000, 1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_INNER_SIZE, 17'd1024,  1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_OUT_COLS,   17'd64,    1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_FIRST_ROW,  17'd100,   1'b0, 0},
        '{STEP_CFG,  rrmm_pkg::CFG_STOP_ROW,   17'd100,   1'b0, 0},
        '{STEP_XFER, rrmm_pkg::MODE_A_ELEM,    17'h05555, 1'b0, 0}
    };

    row_range_matrix_multiply_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_inner(input int raw);
        if (raw < 1) return 1;
        if (raw > rrmm_pkg::DEF_MAX_INNER) return rrmm_pkg::DEF_MAX_INNER;
        return raw;
    endfunction

    function automatic int eff_cols(input int raw);
        if (raw < 1) return 1;
        if (raw > rrmm_pkg::DEF_MAX_COLS) return rrmm_pkg::DEF_MAX_COLS;
        return raw;
    endfunction

    // models one transfer: a b load, or the multiply-accumulate of one a element against a b row
    function automatic void predict_products(input logic mode, input logic [15:0] raw);
        int      cur_row, n_inner, n_cols, addr;
        longint  a_val, prod;
        bit      final_row;
        t_c_elem e;
        last_pushed = 0;
        if (mode == rrmm_pkg::MODE_B_LOAD) begin
            b_mem[b_wp] = raw;
            b_written[b_wp] = 1'b1;
            b_wp = b_wp + 16'd1;
            b_loads++;
            return;
        end
        b_wp = '0;
        cur_row = int'(cfg_first) + int'(row_cnt);
        if (cur_row >= int'(cfg_stop)) begin
            a_ignored++;
            return;
        end
        a_used++;
        n_inner = eff_inner(int'(cfg_inner));
        n_cols = eff_cols(int'(cfg_cols));
        a_val = longint'($signed(raw));
        for (int j = 0; j < n_cols; j++) begin
            addr = (int'(inner_cnt) * n_cols + j) & 16'hFFFF;
            prod = a_val * longint'($signed(b_mem[addr]));
            acc_row[j] = (inner_cnt == 0) ? prod : acc_row[j] + prod;
        end
        if (int'(inner_cnt) + 1 < n_inner) begin
            inner_cnt = inner_cnt + 10'd1;
            return;
        end
        final_row = (cur_row + 1 == int'(cfg_stop));
        for (int j = 0; j < n_cols; j++) begin
            e.row = 16'(cur_row);
            e.col = 6'(j);
            e.sum = acc_row[j][rrmm_pkg::SUM_W-1:0];
            e.last = (j + 1 == n_cols);
            e.done = final_row;
            expected_c.push_back(e);
        end
        last_pushed = n_cols;
        inner_cnt = '0;
        row_cnt = final_row ? 16'd0 : row_cnt + 16'd1;
    endfunction

    // true when the next a element is out of range or reads only b entries that hold data
    function automatic bit a_reads_ok();
        int n_cols, addr;
        if (int'(cfg_first) + int'(row_cnt) >= int'(cfg_stop)) return 1'b1;
        n_cols = eff_cols(int'(cfg_cols));
        for (int j = 0; j < n_cols; j++) begin
            addr = (int'(inner_cnt) * n_cols + j) & 16'hFFFF;
            if (!b_written[addr]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic send_elem(input logic mode, input logic [15:0] val);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= val;
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_products(mode, val);
    endtask

    // hold the sender until every pending result has come out
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_c.size() != 0) @(posedge i_clk);
        repeat (CFG_QUIET) @(posedge i_clk);
    endtask

    task automatic cfg_write(input rrmm_pkg::t_cfg_idx idx, input logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            rrmm_pkg::CFG_INNER_SIZE: cfg_inner = val[10:0];
            rrmm_pkg::CFG_OUT_COLS:   cfg_cols  = val[6:0];
            rrmm_pkg::CFG_FIRST_ROW:  cfg_first = val[15:0];
            rrmm_pkg::CFG_STOP_ROW:   cfg_stop  = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_sizes(input int inner_raw, input int cols_raw, input int first,
                             input int stop);
        drain_results();
        cfg_write(rrmm_pkg::CFG_INNER_SIZE, 17'(inner_raw));
        cfg_write(rrmm_pkg::CFG_OUT_COLS, 17'(cols_raw));
        cfg_write(rrmm_pkg::CFG_FIRST_ROW, 17'(first));
        cfg_write(rrmm_pkg::CFG_STOP_ROW, 17'(stop));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase();
        int inner_raw, cols_raw, first, stop, n_inner, n_cols, rows_left;
        bit empty;
        phases++;
        case ($urandom_range(0, 9))
            0: begin
                inner_raw = $urandom_range(1, 2);
                cols_raw = $urandom_range(33, 64);
            end
            1: begin
                inner_raw = $urandom_range(0, 3);
                cols_raw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
            end
            default: begin
                inner_raw = $urandom_range(1, 6);
                cols_raw = $urandom_range(1, 8);
            end
        endcase
        case ($urandom_range(0, 5))
            0: first = 65535 - $urandom_range(0, 3);
            1: first = $urandom_range(0, 65535);
            default: first = $urandom_range(0, 40);
        endcase
        if (first + int'(row_cnt) > 65535) first = 65535 - int'(row_cnt);
        empty = ($urandom_range(0, 11) == 0);
        if (empty) begin
            stop = $urandom_range(0, first);
        end else begin
            stop = first + int'(row_cnt) + $urandom_range(1, 4);
            if (stop > 65536) stop = 65536;
        end
        case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
            0: ready_pct = 0;
            1: ready_pct = 10;
            default: ready_pct = 35;
        endcase
        set_sizes(inner_raw, cols_raw, first, stop);
        n_inner = eff_inner(inner_raw);
        n_cols = eff_cols(cols_raw);
        for (int k = 0; k < n_inner * n_cols; k++)
            send_elem(rrmm_pkg::MODE_B_LOAD, 16'($urandom));
        if (empty) begin
            repeat ($urandom_range(1, 3)) send_elem(rrmm_pkg::MODE_A_ELEM, 16'($urandom));
            return;
        end
        rows_left = stop - first - int'(row_cnt) + (($urandom_range(0, 3) == 0) ? 1 : 0);
        for (int r = 0; r < rows_left; r++) begin
            for (int k = 0; k < n_inner; k++) begin
                // row cut short, picked up by the next setting
                if ($urandom_range(0, 299) == 0) return;
                if ($urandom_range(0, 99) == 0) drain_results();
                if (a_reads_ok()) begin
                    if (!quiet && $urandom_range(0, 29) == 0)
                        send_elem(rrmm_pkg::MODE_B_LOAD, 16'($urandom));
                    send_elem(rrmm_pkg::MODE_A_ELEM, 16'($urandom));
                end
            end
        end
    endtask

    task automatic check_result();
        t_c_elem want;
        logic [rrmm_pkg::ROW_W-1:0] got_row;
        logic [rrmm_pkg::COL_W-1:0] got_col;
        logic [rrmm_pkg::SUM_W-1:0] got_sum;
        got_row = o_m_axis_tdata[rrmm_pkg::ROW_W-1:0];
        got_col = o_m_axis_tdata[rrmm_pkg::ROW_W+rrmm_pkg::COL_W-1:rrmm_pkg::ROW_W];
        got_sum = o_m_axis_tdata[rrmm_pkg::OUT_TDATA_W-1:rrmm_pkg::ROW_W+rrmm_pkg::COL_W];
        results_seen++;
        if (o_m_axis_tlast) rows_seen++;
        if (expected_c.size() == 0) begin
            flag_mismatch($sformatf("unexpected result row %0d col %0d", got_row, got_col));
            return;
        end
        want = expected_c.pop_front();
        if (got_row !== want.row)
            flag_mismatch($sformatf("row %0d, want %0d", got_row, want.row));
        if (got_col !== want.col)
            flag_mismatch($sformatf("row %0d col %0d, want col %0d", want.row, got_col, want.col));
        if (got_sum !== want.sum)
            flag_mismatch($sformatf("row %0d col %0d sum %0d, want %0d", want.row, want.col,
                                    $signed(got_sum), $signed(want.sum)));
        if (o_m_axis_tlast !== want.last)
            flag_mismatch($sformatf("row %0d col %0d tlast %b, want %b", want.row, want.col,
                                    o_m_axis_tlast, want.last));
        if (o_m_axis_tuser !== want.done)
            flag_mismatch($sformatf("row %0d col %0d tuser %b, want %b", want.row, want.col,
                                    o_m_axis_tuser, want.done));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) check_result();
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (quiet || ready_pct == 0) begin
            i_m_axis_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < ready_pct) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_c.size());
            $display("row_range_matrix_multiply_core regression: fail");
            $finish;
        end
    end

    initial begin
        bit prev_cfg;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        for (int s = 0; s < N_STEPS; s++) begin
            if (dir_steps[s].kind == STEP_CFG) begin
                if (!prev_cfg) drain_results();
                cfg_write(rrmm_pkg::t_cfg_idx'(dir_steps[s].sel), dir_steps[s].data);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                send_elem(dir_steps[s].sel[0], dir_steps[s].data[15:0]);
                if (dir_steps[s].typed && last_pushed == 1)
                    expected_c[expected_c.size()-1].sum =
                        dir_steps[s].sum[rrmm_pkg::SUM_W-1:0];
                prev_cfg = 1'b0;
            end
        end

        while (b_loads + a_used < RANDOM_ITEMS) begin
            run_phase();
            if (b_loads + a_used >= RANDOM_ITEMS - 60) quiet = 1'b1;
        end

        i_s_axis_tvalid <= 1'b0;
        while (expected_c.size() != 0) @(posedge i_clk);
        repeat (END_QUIET) @(posedge i_clk);

        $display("stimulus: %0d b loads, %0d a elements used, %0d ignored, %0d config writes, %0d phases",
                 b_loads, a_used, a_ignored, cfg_writes, phases);
        $display("checked %0d results over %0d rows, %0d mismatches", results_seen, rows_seen,
                 errors);
        if (errors == 0) begin
            $display("row_range_matrix_multiply_core regression: pass");
        end else begin
            $display("row_range_matrix_multiply_core regression: fail");
        end
        $finish;
    end

endmodule
